FILE: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  // Payload width of one stored entry
  localparam int unsigned DATA_W = 32;
  // Width of the reported entry count
  localparam int unsigned COUNT_OUT_W = 4;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;  // insert the incoming value in sorted place
    logic pop;   // shift every entry one place toward the head
  } cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
// One compare-and-shift cell of the sorted queue chain.
module spq_cell import spq_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] value,
  input  logic              occ,
  input  logic              prev_ge,
  input  logic [DATA_W-1:0] prev_entry,
  input  logic [DATA_W-1:0] next_entry,
  output logic [DATA_W-1:0] entry,
  output logic              ge
);

  logic [DATA_W-1:0] entry_next;

  // Occupied entry that stays ahead of the incoming value
  assign ge = occ && ($signed(entry) >= $signed(value));

  // Keep, take the new value, or take a neighbor's entry
  always_comb begin
    entry_next = entry;
    priority if (ctrl.push) begin
      priority if (ge) begin
        entry_next = entry;
      end else if (prev_ge) begin
        entry_next = value;
      end else begin
        entry_next = prev_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = next_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// Sorted priority queue: command channel in, one result beat per command out.
//
// Usage:
//   A command (op, value) is taken at a rising edge where start is high and
//   busy is low. op = enqueue inserts value behind every stored entry that is
//   greater than or equal to it; op = dequeue removes the head entry.
//   Each command yields exactly one result beat in the next cycle: strobe is
//   high for that single cycle with status, head_value, entry_count, is_empty
//   and is_full describing the queue after the command.
//   Throughput is one command per cycle, set by the row
//   of CAPACITY compare-and-shift cells that all update at the same edge.
//   busy stays low, so commands may be issued back to back.
//   A full enqueue reports status full and leaves the queue unchanged; an
//   empty dequeue reports status empty likewise.
//   Reset (rst, synchronous) empties the queue and drops any pending strobe;
//   stored entries are not cleared, only the count is.
//   The receiver cannot stall: each result beat must be taken when shown.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op,
  input  logic [DATA_W-1:0]      value,
  output logic                   strobe,
  output logic [1:0]             status,
  output logic [DATA_W-1:0]      head_value,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output logic                   is_empty,
  output logic                   is_full
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  status_t           status_q;
  status_t           status_next;
  logic              accept;
  logic              full_now;
  logic              empty_now;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] occ;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full_now  = (count == CW'(CAPACITY));
  assign empty_now = (count == '0);

  // Command decode
  always_comb begin
    ctrl.push   = 1'b0;
    ctrl.pop    = 1'b0;
    status_next = ST_DONE;
    count_next  = count;
    if (accept) begin
      unique case (op)
        OP_ENQ: begin
          if (full_now) begin
            status_next = ST_FULL;
          end else begin
            ctrl.push  = 1'b1;
            count_next = count + CW'(1);
          end
        end
        OP_DEQ: begin
          if (empty_now) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.pop   = 1'b1;
            count_next = count - CW'(1);
          end
        end
        default: status_next = ST_DONE;
      endcase
    end
  end

  // Cell chain: cell 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              prev_ge_c;
    logic [DATA_W-1:0] prev_entry_c;
    logic [DATA_W-1:0] next_entry_c;

    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign prev_ge_c    = 1'b1;
      assign prev_entry_c = value;
    end else begin : g_body
      assign prev_ge_c    = ge[i-1];
      assign prev_entry_c = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry_c = entries[i];
    end else begin : g_mid
      assign next_entry_c = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .value      (value),
      .occ        (occ[i]),
      .prev_ge    (prev_ge_c),
      .prev_entry (prev_entry_c),
      .next_entry (next_entry_c),
      .entry      (entries[i]),
      .ge         (ge[i])
    );
  end

  // Count, strobe and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      strobe   <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      count    <= count_next;
      strobe   <= accept;
      status_q <= status_next;
    end
  end

  // Result beat reflects state after the command
  assign status      = status_q;
  assign head_value  = empty_now ? {DATA_W{1'b1}} : entries[0];
  assign entry_count = COUNT_OUT_W'(count);
  assign is_empty    = empty_now;
  assign is_full     = full_now;

  // Count never passes capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("queue count above capacity");

  // One result beat per accepted command, in the cycle after it
  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> strobe)
    else $error("missing result beat");

  // Full rejection only when the queue was and stays full
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (strobe && status_q == ST_FULL) |-> (full_now && $stable(count)))
    else $error("full rejection with room left");

  // Empty rejection leaves the queue empty
  a_empty_reject: assert property (@(posedge clk) disable iff (rst)
    (strobe && status_q == ST_EMPTY) |-> empty_now)
    else $error("empty rejection with entries stored");

endmodule

FILE: verif/sorted_priority_queue_top_test.sv
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
module sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int unsigned DEPTH = 8;

  // Expected contents of one result beat
  typedef struct packed {
    status_t                status;
    logic [DATA_W-1:0]      head;
    logic [COUNT_OUT_W-1:0] count;
    logic                   empty;
    logic                   full;
  } queue_result_t;

  // One command beat, with an optional typed-in expectation
  typedef struct packed {
    logic          op;
    logic [31:0]   value;
    logic          fixed;
    queue_result_t want;
  } cmd_row_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   op;
  logic [DATA_W-1:0]      value;
  logic                   strobe;
  logic [1:0]             status;
  logic [DATA_W-1:0]      head_value;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   is_empty;
  logic                   is_full;

  // Travels with the command so the monitor knows which expectation to use
  logic          row_fixed;
  queue_result_t row_want;

  // Shadow copy of the sorted store
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int unsigned              shadow_count;

  queue_result_t pending_results [$];
  int unsigned   fails;
  cmd_row_t      directed_rows [$];

  sorted_priority_queue_top #(.CAPACITY(DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .value       (value),
    .strobe      (strobe),
    .status      (status),
    .head_value  (head_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the shadow store and report the queue afterward
  function automatic queue_result_t queue_apply(input logic cmd_op,
                                                input logic signed [DATA_W-1:0] v);
    queue_result_t r;
    int pos;
    r.status = ST_DONE;
    if (cmd_op == OP_ENQ) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = shadow_count;
        // shift smaller entries back; stop at the head
        while (pos > 0 && shadow_entries[pos-1] < v) begin
          shadow_entries[pos] = shadow_entries[pos-1];
          pos--;
        end
        shadow_entries[pos] = v;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (int k = 0; k + 1 < shadow_count; k++)
          shadow_entries[k] = shadow_entries[k+1];
        shadow_count--;
      end
    end
    r.head  = (shadow_count == 0) ? '1 : shadow_entries[0];
    r.count = shadow_count[COUNT_OUT_W-1:0];
    r.empty = (shadow_count == 0);
    r.full  = (shadow_count == DEPTH);
    return r;
  endfunction

  function automatic cmd_row_t mk_row(input logic o, input logic [31:0] v,
                                      input logic fx, input status_t st,
                                      input logic [31:0] hd, input int unsigned cnt,
                                      input logic em, input logic fu);
    cmd_row_t r;
    r.op         = o;
    r.value      = v;
    r.fixed      = fx;
    r.want.status = st;
    r.want.head  = hd;
    r.want.count = cnt[COUNT_OUT_W-1:0];
    r.want.empty = em;
    r.want.full  = fu;
    return r;
  endfunction

  // Result checker and command monitor
  always @(posedge clk) begin
    queue_result_t exp_r;
    queue_result_t got;
    if (rst) begin
      shadow_count = 0;
    end else begin
      if (strobe) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fails++;
        end else begin
          exp_r = pending_results.pop_front();
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            fails++;
          end
          if (head_value !== exp_r.head) begin
            $error("head_value: expected %h, got %h", exp_r.head, head_value);
            fails++;
          end
          if (entry_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, entry_count);
            fails++;
          end
          if (is_empty !== exp_r.empty) begin
            $error("is_empty: expected %0b, got %0b", exp_r.empty, is_empty);
            fails++;
          end
          if (is_full !== exp_r.full) begin
            $error("is_full: expected %0b, got %0b", exp_r.full, is_full);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        got = queue_apply(op, value);
        pending_results.push_back(row_fixed ? row_want : got);
      end
    end
  end

  // Offer one command beat after a random gap; return once it is taken
  task automatic send_beat(input cmd_row_t r, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    op        <= r.op;
    value     <= r.value;
    row_fixed <= r.fixed;
    row_want  <= r.want;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every outstanding result beat has arrived
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom_range(8) - 4;  // clustered, lots of ties
      1: begin
        case ($urandom_range(3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Stimulus
  initial begin
    cmd_row_t    r;
    int unsigned idle;
    int unsigned enq_pct;
    int unsigned waited;
    clk       = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    op        = OP_ENQ;
    value     = '0;
    row_fixed = 1'b0;
    row_want  = '0;
    fails     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table: empty dequeue, extremes, ties, full, drain
    directed_rows.push_back(mk_row(OP_DEQ, 32'h1234_5678, 1, ST_EMPTY, '1, 0, 1, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'h0000_0000, 1, ST_DONE, 32'h0, 1, 0, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'h7fff_ffff, 1, ST_DONE, 32'h7fff_ffff, 2, 0, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'h8000_0000, 0, ST_DONE, '0, 0, 0, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'hffff_ffff, 0, ST_DONE, '0, 0, 0, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'h0000_0005, 0, ST_DONE, '0, 0, 0, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'h0000_0005, 0, ST_DONE, '0, 0, 0, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'h7fff_ffff, 0, ST_DONE, '0, 0, 0, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'h5555_5555, 1, ST_DONE, 32'h7fff_ffff, 8, 0, 1));
    directed_rows.push_back(mk_row(OP_ENQ, 32'haaaa_aaaa, 1, ST_FULL, 32'h7fff_ffff, 8, 0, 1));
    for (int i = 0; i < 8; i++)
      directed_rows.push_back(mk_row(OP_DEQ, (i % 2) ? 32'hffff_ffff : 32'h0, 0,
                                     ST_DONE, '0, 0, 0, 0));
    directed_rows.push_back(mk_row(OP_DEQ, 32'hffff_ffff, 1, ST_EMPTY, '1, 0, 1, 0));
    directed_rows.push_back(mk_row(OP_ENQ, 32'h8000_0000, 0, ST_DONE, '0, 0, 0, 0));
    directed_rows.push_back(mk_row(OP_DEQ, 32'h0, 1, ST_DONE, '1, 0, 1, 0));
    foreach (directed_rows[i])
      send_beat(directed_rows[i], 33);
    drain_results();

    // random traffic; enqueue bias is redrawn at random between high and low so the queue swings between full and empty
    for (int phase = 0; phase < 3; phase++) begin
      idle = (phase == 0) ? 33 : (phase == 1) ? 68 : 0;
      enq_pct = 50;
      for (int i = 0; i < 333; i++) begin
        if (i % 24 == 0)
          enq_pct = $urandom_range(1) ? 75 : 25;
        r = '0;
        r.op    = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        r.value = pick_value();
        send_beat(r, idle);
      end
      drain_results();
    end

    // wind down
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
